>>> rtl/rrdsb_pkg.sv
// rrdsb_pkg: shared constants, register indexes and FSM type for the
// RRIP replacement unit with set dueling and stream bypass.
// No dependencies.
package rrdsb_pkg;

	// parameter defaults
	localparam int SET_COUNT_DEF     = 2048;
	localparam int WAY_COUNT_DEF     = 16;
	localparam int FAR_LEADER_DEF    = 32;
	localparam int NEAR_LEADER_DEF   = 32;
	localparam int SELECTOR_BITS_DEF = 10;

	// fixed field widths
	localparam int SET_IDX_W  = 11;
	localparam int WAY_IDX_W  = 4;
	localparam int PADDR_W    = 64;
	localparam int RR_W       = 2;
	localparam int CNT_W      = 3;
	localparam int SEL_THR_W  = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// re-reference values
	localparam logic [RR_W-1:0] RR_MAX  = 2'd3;
	localparam logic [RR_W-1:0] RR_NEAR = 2'd2;
	localparam logic [RR_W-1:0] RR_HIT  = 2'd0;

	localparam logic [CNT_W-1:0] REPEAT_MAX = 3'd7;

	// config reset values
	localparam logic [CNT_W-1:0]     STREAM_THR_RST = 3'd4;
	localparam logic [SEL_THR_W-1:0] SEL_THR_RST    = 10'd511;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STREAM_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_THR    = 2'd1;

	// commands
	localparam logic CMD_VICTIM = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

>>> rtl/rrip_dueling_replacement_stream_bypass_unit.sv
// Top level: SRRIP replacement with DIP-style set dueling and a per-set
// stride detector that fills streaming sets at distant re-reference.
// Depends on rrdsb_pkg.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  command   | start / busy              | command, set_index, way_index, was_hit,
//            |                           | phys_address
//  result    | result_valid (strobe)     | victim_way, insert_value, stream_seen
//  config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A beat reads the set's rows from both memories into stage 1, then modifies and
// writes them back in the execute state. The result strobe is registered from
// the execute state and busy drops in the strobe cycle, so no new beat is taken
// before the last result. After reset a clearing pass writes every set with busy
// high; config writes are taken at any time. The receiver cannot stall results.
module rrip_dueling_replacement_stream_bypass_unit import rrdsb_pkg::*; #(
	parameter int SET_COUNT        = SET_COUNT_DEF,
	parameter int WAY_COUNT        = WAY_COUNT_DEF,
	parameter int FAR_LEADER_SETS  = FAR_LEADER_DEF,
	parameter int NEAR_LEADER_SETS = NEAR_LEADER_DEF,
	parameter int SELECTOR_BITS    = SELECTOR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  start,
	output logic                  busy,
	input  logic                  command,
	input  logic [SET_IDX_W-1:0]  set_index,
	input  logic [WAY_IDX_W-1:0]  way_index,
	input  logic                  was_hit,
	input  logic [PADDR_W-1:0]    phys_address,
	// result channel
	output logic                  result_valid,
	output logic [WAY_IDX_W-1:0]  victim_way,
	output logic [RR_W-1:0]       insert_value,
	output logic                  stream_seen,
	// config channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SET_W = $clog2(SET_COUNT);
	localparam int ROW_W = WAY_COUNT * RR_W;
	localparam int STR_W = 2 * PADDR_W + CNT_W;
	// quotient bits of set_index / SET_COUNT
	localparam int QBITS = $clog2((2**SET_IDX_W - 1) / SET_COUNT + 1);
	localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = '1;
	localparam logic [SELECTOR_BITS-1:0] SEL_RST  = SEL_MAX >> 1;
	localparam logic [SET_W-1:0]         SET_LAST = SET_W'(SET_COUNT - 1);

	// ---------------------------------------------------------------- control
	state_t            state_q, state_d;
	logic [SET_W-1:0]  clr_addr_q;
	logic              accept;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == SET_LAST)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------- config
	logic [CNT_W-1:0]     stream_thr_q;
	logic [SEL_THR_W-1:0] sel_thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_thr_q <= STREAM_THR_RST;
			sel_thr_q    <= SEL_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_STREAM_THR)
				stream_thr_q <= cfg_data[CNT_W-1:0];
			else if (cfg_index == REG_SEL_THR)
				sel_thr_q <= cfg_data[SEL_THR_W-1:0];
		end
	end

	// ---------------------------------------------------------------- set reduction
	// restoring subtract of SET_COUNT multiples, one quotient bit per step
	logic [SET_IDX_W-1:0] set_mod;
	logic [SET_W-1:0]     set_addr;

	always_comb begin
		set_mod = set_index;
		for (int i = QBITS - 1; i >= 0; i--) begin
			if (int'(set_mod) >= (SET_COUNT << i))
				set_mod = SET_IDX_W'(int'(set_mod) - (SET_COUNT << i));
		end
		set_addr = SET_W'(set_mod);
	end

	// ---------------------------------------------------------------- stage 1 regs
	logic                 cmd_s1;
	logic [SET_W-1:0]     set_s1;
	logic [WAY_IDX_W-1:0] way_s1;
	logic                 hit_s1;
	logic [PADDR_W-1:0]   addr_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			set_s1  <= set_addr;
			way_s1  <= way_index;
			hit_s1  <= was_hit;
			addr_s1 <= phys_address;
		end
	end

	// ---------------------------------------------------------------- memories
	logic [ROW_W-1:0] rr_mem [SET_COUNT];
	logic [STR_W-1:0] str_mem [SET_COUNT];
	logic [ROW_W-1:0] rr_rdata_s1;
	logic [STR_W-1:0] str_rdata_s1;
	logic             rr_we, str_we;
	logic [SET_W-1:0] waddr;
	logic [ROW_W-1:0] rr_wdata;
	logic [STR_W-1:0] str_wdata;

	always_ff @(posedge clk) begin
		if (rr_we)
			rr_mem[waddr] <= rr_wdata;
		if (accept)
			rr_rdata_s1 <= rr_mem[set_addr];
	end

	always_ff @(posedge clk) begin
		if (str_we)
			str_mem[waddr] <= str_wdata;
		if (accept)
			str_rdata_s1 <= str_mem[set_addr];
	end

	// ---------------------------------------------------------------- victim path
	logic [RR_W-1:0]      top;
	logic                 any3, any2, any1;
	logic [ROW_W-1:0]     aged_row;
	logic [WAY_IDX_W-1:0] vic;

	always_comb begin
		any3 = 1'b0;
		any2 = 1'b0;
		any1 = 1'b0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			any3 |= (rr_rdata_s1[w*RR_W +: RR_W] == 2'd3);
			any2 |= (rr_rdata_s1[w*RR_W +: RR_W] == 2'd2);
			any1 |= (rr_rdata_s1[w*RR_W +: RR_W] == 2'd1);
		end
		top = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
		// aging adds the same amount to every way
		for (int w = 0; w < WAY_COUNT; w++)
			aged_row[w*RR_W +: RR_W] = rr_rdata_s1[w*RR_W +: RR_W] + (RR_MAX - top);
		vic = '0;
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (rr_rdata_s1[w*RR_W +: RR_W] == top)
				vic = WAY_IDX_W'(w);
		end
	end

	// ---------------------------------------------------------------- update path
	logic [PADDR_W-1:0]       prev_addr, prev_stride, stride;
	logic [CNT_W-1:0]         cnt, cnt_n;
	logic                     streaming, far_ldr, near_ldr, follow_near, way_ok;
	logic [RR_W-1:0]          fill, ins;
	logic [ROW_W-1:0]         upd_row;
	logic [SELECTOR_BITS-1:0] sel_q;

	always_comb begin
		prev_addr   = str_rdata_s1[STR_W-1 -: PADDR_W];
		prev_stride = str_rdata_s1[CNT_W +: PADDR_W];
		cnt         = str_rdata_s1[CNT_W-1:0];
		stride      = (prev_addr != '0) ? addr_s1 - prev_addr : '0;
		if (stride != '0 && stride == prev_stride)
			cnt_n = (cnt == REPEAT_MAX) ? cnt : cnt + 1'b1;
		else
			cnt_n = '0;
		streaming   = (cnt_n >= stream_thr_q);
		far_ldr     = int'(set_s1) < FAR_LEADER_SETS;
		near_ldr    = !far_ldr && int'(set_s1) < (FAR_LEADER_SETS + NEAR_LEADER_SETS);
		follow_near = int'(sel_q) >= int'(sel_thr_q);
		if (streaming || far_ldr)
			fill = RR_MAX;
		else if (near_ldr || follow_near)
			fill = RR_NEAR;
		else
			fill = RR_MAX;
		ins    = hit_s1 ? RR_HIT : fill;
		way_ok = int'(way_s1) < WAY_COUNT;
		upd_row = rr_rdata_s1;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (int'(way_s1) == w)
				upd_row[w*RR_W +: RR_W] = ins;
		end
	end

	// write-back select: clearing pass or execute cycle
	always_comb begin
		if (state_q == ST_CLEAR) begin
			rr_we     = 1'b1;
			str_we    = 1'b1;
			waddr     = clr_addr_q;
			rr_wdata  = {WAY_COUNT{RR_MAX}};
			str_wdata = '0;
		end else begin
			rr_we     = (state_q == ST_EXEC) && ((cmd_s1 == CMD_VICTIM) || way_ok);
			str_we    = (state_q == ST_EXEC) && (cmd_s1 == CMD_UPDATE) && !hit_s1;
			waddr     = set_s1;
			rr_wdata  = (cmd_s1 == CMD_VICTIM) ? aged_row : upd_row;
			str_wdata = {addr_s1, stride, cnt_n};
		end
	end

	// dueling selector, moved only by non-streaming leader misses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= SEL_RST;
		end else if (str_we && (state_q == ST_EXEC) && !streaming) begin
			if (far_ldr && sel_q != SEL_MAX)
				sel_q <= sel_q + 1'b1;
			else if (near_ldr && sel_q != '0)
				sel_q <= sel_q - 1'b1;
		end
	end

	// ---------------------------------------------------------------- result
	logic                 res_valid_q;
	logic [WAY_IDX_W-1:0] victim_q;
	logic [RR_W-1:0]      insert_q;
	logic                 stream_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else
			res_valid_q <= (state_q == ST_EXEC);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			victim_q <= (cmd_s1 == CMD_VICTIM) ? vic : '0;
			insert_q <= (cmd_s1 == CMD_UPDATE) ? ins : RR_HIT;
			stream_q <= (cmd_s1 == CMD_UPDATE) && !hit_s1 && streaming;
		end
	end

	assign result_valid = res_valid_q;
	assign victim_way   = victim_q;
	assign insert_value = insert_q;
	assign stream_seen  = stream_q;

endmodule

>>> rtl/rrdsb_chk.sv
// rrdsb_chk: port-level assertions for the RRIP replacement unit, bound to
// the top level. Depends on rrdsb_pkg.
module rrdsb_chk import rrdsb_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 command,
	input logic                 was_hit,
	input logic                 result_valid,
	input logic [WAY_IDX_W-1:0] victim_way,
	input logic [RR_W-1:0]      insert_value,
	input logic                 stream_seen
);

	// every accepted beat is followed by exactly one result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 result_valid)
		else $error("missing result two cycles after accept");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, 2))
		else $error("result without matching accept");

	// victim beats report no insert value or stream flag
	a_victim_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_VICTIM) |-> ##2 (insert_value == RR_HIT && !stream_seen))
		else $error("victim result carries update fields");

	// hit updates report all-zero result
	a_hit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_UPDATE && was_hit) |->
			##2 (victim_way == '0 && insert_value == RR_HIT && !stream_seen))
		else $error("hit update result not zero");

	// a streaming fill always goes in at distant re-reference
	a_stream_max: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && stream_seen) |-> insert_value == RR_MAX)
		else $error("streaming fill not at max value");

endmodule

bind rrip_dueling_replacement_stream_bypass_unit rrdsb_chk u_rrdsb_chk (.*);
